// File: design/fba_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the frame bitmap allocator: field widths, status codes,
// register reset value and default sizing. No dependencies.
package fba_pkg;

    localparam int FRAME_W  = 20;
    localparam int CFG_W    = 16;
    localparam int STATUS_W = 2;

    localparam int MAX_FRAMES_DEF = 32768;
    localparam int WORD_BITS_DEF  = 32;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 16'd32768;

    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } t_state;

endpackage

// File: design/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// Top level of the frame bitmap allocator: request FSM, word scan, result regs.
// Depends on fba_pkg and fba_bitmap_mem.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-----------------------------------
//  request   | in        | start & !busy          | i_current_frame, i_is_kernel,
//            |           |                        | i_is_writable
//  result    | out       | o_done (one cycle)     | o_frame, o_present, o_writable,
//            |           |                        | o_user_access, o_status
//  config    | in        | i_cfg_valid&o_cfg_ready| i_cfg_data (frame_count)
//
// A mapped request goes from the accepting state straight to the result strobe.
// An allocation scans W bitmap words before its result strobe, W being one when the frame
// count is zero, else at most ceil(min(frame_count, MAX_FRAMES) / WORD_BITS);
// the single memory read port sets one word a cycle.
// Reset: synchronous, active low; frame_count returns to 32768 and the bitmap
// reads as all free at once through a fill mark (no clearing pass).
// Stalls: the receiver cannot stall; busy holds off requests through the result beat.
module frame_bitmap_allocator
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FRAME_W-1:0]  i_current_frame,
    input  logic                i_is_kernel,
    input  logic                i_is_writable,
    output logic                o_done,
    output logic [FRAME_W-1:0]  o_frame,
    output logic                o_present,
    output logic                o_writable,
    output logic                o_user_access,
    output logic [STATUS_W-1:0] o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int NB_W  = $clog2(WORD_BITS + 1);
    localparam int LFT_W = (CNT_W > NB_W) ? CNT_W : NB_W;
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int IW    = $clog2(WORD_BITS);

    // Encode the position of a one-hot bit.
    function automatic logic [IW-1:0] onehot_index(input logic [WORD_BITS-1:0] oh);
        logic [IW-1:0] idx;
        idx = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (oh[b]) begin
                idx = idx | IW'(b);
            end
        end
        return idx;
    endfunction

    t_state               r_state;
    logic [CFG_W-1:0]     r_frame_count;
    logic [CNT_W-1:0]     r_limit;
    logic [LFT_W-1:0]     r_left;
    logic [AW-1:0]        r_daddr;
    logic                 r_kern;
    logic                 r_wr;
    logic [FRAME_W-1:0]   r_frame;
    logic                 r_present;
    logic                 r_writable;
    logic                 r_user;
    logic [STATUS_W-1:0]  r_status;

    logic                 accept;
    logic [LIM_W-1:0]     limit_sat;
    logic [AW-1:0]        daddr_next;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] mem_q;
    logic [NB_W-1:0]      nb;
    logic [WORD_BITS:0]   low_ones;
    logic [WORD_BITS-1:0] scan_word;
    logic [WORD_BITS-1:0] hit_1h;
    logic                 hit;
    logic                 last_word;
    logic [IW-1:0]        hit_idx;
    logic [CNT_W-1:0]     frame_idx;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Saturate the configured count at the bitmap capacity.
    assign limit_sat = (LIM_W'(r_frame_count) > LIM_W'(MAX_FRAMES)) ?
                       LIM_W'(MAX_FRAMES) : LIM_W'(r_frame_count);

    // Read ahead one word: word 0 sits on the read port while idle.
    assign daddr_next = (r_daddr == AW'(WORDS - 1)) ? '0 : r_daddr + 1'b1;
    assign rd_addr    = (r_state == S_SCAN) ? daddr_next : '0;

    // Treat frames at or past the limit as taken.
    assign nb        = (r_left >= LFT_W'(WORD_BITS)) ? NB_W'(WORD_BITS) : NB_W'(r_left);
    assign low_ones  = ({{WORD_BITS{1'b0}}, 1'b1} << nb) - {{WORD_BITS{1'b0}}, 1'b1};
    assign scan_word = mem_q | ~low_ones[WORD_BITS-1:0];
    assign hit_1h    = ~scan_word & (scan_word + 1'b1);
    assign hit       = ~&scan_word;
    assign last_word = (r_left <= LFT_W'(WORD_BITS));
    assign hit_idx   = onehot_index(hit_1h);
    assign frame_idx = CNT_W'(r_daddr) * CNT_W'(WORD_BITS) + CNT_W'(hit_idx);

    // Set the found bit in the same cycle it is found.
    assign wr_en   = (r_state == S_SCAN) && hit;
    assign wr_data = mem_q | hit_1h;

    fba_bitmap_mem #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_daddr),
        .i_wr_data (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frame_count <= i_cfg_data;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (i_current_frame != '0) ? S_RESP : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit || last_word) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Scan counters, request flags and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_daddr    <= '0;
            r_left     <= LFT_W'(limit_sat);
            r_limit    <= CNT_W'(limit_sat);
            r_kern     <= i_is_kernel;
            r_wr       <= i_is_writable;
            r_frame    <= i_current_frame;
            r_present  <= 1'b0;
            r_writable <= 1'b0;
            r_user     <= 1'b0;
            r_status   <= ST_MAPPED;
        end else if (r_state == S_SCAN) begin
            if (hit) begin
                r_frame    <= FRAME_W'(frame_idx);
                r_present  <= 1'b1;
                r_writable <= r_wr;
                r_user     <= ~r_kern;
                r_status   <= ST_ALLOC;
            end else if (last_word) begin
                r_frame    <= '0;
                r_present  <= 1'b0;
                r_writable <= 1'b0;
                r_user     <= 1'b0;
                r_status   <= ST_FULL;
            end else begin
                // Advance to the next word
                r_daddr <= daddr_next;
                r_left  <= r_left - LFT_W'(WORD_BITS);
            end
        end
    end

    assign o_done        = (r_state == S_RESP);
    assign o_frame       = r_frame;
    assign o_present     = r_present;
    assign o_writable    = r_writable;
    assign o_user_access = r_user;
    assign o_status      = r_status;

    // A mapped request goes straight from the accepting cycle to the result beat.
    a_result_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result beat without a request in flight");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_write_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_SCAN) && (r_left != '0))
        else $error("bitmap write outside an active scan");

    a_alloc_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_ALLOC) |-> (CNT_W'(o_frame) < r_limit) && o_present)
        else $error("allocated frame at or past the frame count");

endmodule

// File: design/fba_bitmap_mem.sv
`timescale 1ns / 1ps
// Bitmap word store: one write port, one registered read port.
// A fill mark masks never-written words to zero. No package dependencies.
module fba_bitmap_mem #(
    parameter int WORDS     = 1024,
    parameter int WORD_BITS = 32,
    parameter int AW        = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_q;
    logic [AW-1:0]        r_q_addr;
    logic [AW:0]          r_fill;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q      <= r_mem[i_rd_addr];
        r_q_addr <= i_rd_addr;
    end

    // Written words always form a prefix, so one mark replaces a clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en && ({1'b0, i_wr_addr} >= r_fill)) begin
            r_fill <= {1'b0, i_wr_addr} + 1'b1;
        end
    end

    assign o_rd_data = ({1'b0, r_q_addr} < r_fill) ? r_q : '0;

endmodule

// File: tb/sv/fba_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the frame bitmap allocator bench: a shadow copy of the frame bitmap
// and of frame_count, and the queue of page entries still owed by the block.
// Depends on fba_pkg for widths, status codes and the default frame capacity.
package fba_tb_pkg;
    import fba_pkg::*;

    typedef struct {
        logic [FRAME_W-1:0]  frame;
        logic                present;
        logic                writable;
        logic                user_access;
        logic [STATUS_W-1:0] status;
    } t_page_entry;

    class frame_alloc_tracker;
        bit [MAX_FRAMES_DEF-1:0] frame_used;
        logic [CFG_W-1:0]        frame_count;
        int unsigned             frames_in_use;
        int unsigned             errors;
        t_page_entry             owed_entries[$];

        function new();
            frame_used    = '0;
            frame_count   = FRAME_COUNT_RST;
            frames_in_use = 0;
            errors        = 0;
        endfunction

        function void set_frame_count(input logic [CFG_W-1:0] value);
            frame_count = value;
        endfunction

        function int pending();
            return owed_entries.size();
        endfunction

        // Work out the page entry for one request and update the shadow bitmap.
        function void note_request(input logic [FRAME_W-1:0] cur_frame,
                                   input logic kernel, input logic wr);
            t_page_entry entry;
            int unsigned limit;
            int unsigned f;
            entry.frame       = '0;
            entry.present     = 1'b0;
            entry.writable    = 1'b0;
            entry.user_access = 1'b0;
            entry.status      = ST_FULL;
            limit = (frame_count > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frame_count;
            if (cur_frame != '0) begin
                entry.frame  = cur_frame;
                entry.status = ST_MAPPED;
            end else begin
                for (f = 0; f < limit; f++) begin
                    if (!frame_used[f]) begin
                        frame_used[f]     = 1'b1;
                        frames_in_use++;
                        entry.frame       = f[FRAME_W-1:0];
                        entry.present     = 1'b1;
                        entry.writable    = wr;
                        entry.user_access = ~kernel;
                        entry.status      = ST_ALLOC;
                        break;
                    end
                end
            end
            owed_entries.push_back(entry);
        endfunction

        function void check_result(input t_page_entry got);
            t_page_entry want;
            if (owed_entries.size() == 0) begin
                $error("result beat with no request outstanding: frame %0h status %0d",
                       got.frame, got.status);
                errors++;
                return;
            end
            want = owed_entries.pop_front();
            if (got.frame !== want.frame) begin
                $error("frame: expected %0h, got %0h", want.frame, got.frame);
                errors++;
            end
            if (got.present !== want.present) begin
                $error("present: expected %0b, got %0b", want.present, got.present);
                errors++;
            end
            if (got.writable !== want.writable) begin
                $error("writable: expected %0b, got %0b", want.writable, got.writable);
                errors++;
            end
            if (got.user_access !== want.user_access) begin
                $error("user_access: expected %0b, got %0b",
                       want.user_access, got.user_access);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the frame bitmap allocator bench: clock, reset, request and frame_count
// drivers, result monitor and watchdog. Depends on fba_pkg, fba_tb_pkg and the RTL.
module tb_top;
    import fba_pkg::*;
    import fba_tb_pkg::*;

    // Longest stretch without any beat: one full 1024-word scan plus a sender gap,
    // taken many times over.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 56;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FRAME_W-1:0]  i_current_frame;
    logic                i_is_kernel;
    logic                i_is_writable;
    logic                o_done;
    logic [FRAME_W-1:0]  o_frame;
    logic                o_present;
    logic                o_writable;
    logic                o_user_access;
    logic [STATUS_W-1:0] o_status;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data;

    frame_alloc_tracker tracker;
    int unsigned        idle_pct;
    int unsigned        quiet_cycles;

    frame_bitmap_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_current_frame(i_current_frame),
        .i_is_kernel    (i_is_kernel),
        .i_is_writable  (i_is_writable),
        .o_done         (o_done),
        .o_frame        (o_frame),
        .o_present      (o_present),
        .o_writable     (o_writable),
        .o_user_access  (o_user_access),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Monitor: sample both channels at the edge that accepts a beat. Check the result
    // before noting a new request so a stray result cannot match a fresh entry.
    always @(posedge i_clk) begin
        t_page_entry got;
        if (i_rst_n === 1'b1) begin
            if (o_done === 1'b1) begin
                got.frame       = o_frame;
                got.present     = o_present;
                got.writable    = o_writable;
                got.user_access = o_user_access;
                got.status      = o_status;
                tracker.check_result(got);
            end
            if (start && busy === 1'b0)
                tracker.note_request(i_current_frame, i_is_kernel, i_is_writable);
        end
    end

    // Watchdog: count cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && busy === 1'b0) || o_done === 1'b1
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request. Idle first with the current probability, then hold start
    // until the block takes the beat. Leave start high on return, so a back-to-back
    // request needs only one assignment to start in that step.
    task automatic send_request(input logic [FRAME_W-1:0] cur_frame,
                                input logic kernel, input logic wr);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_current_frame <= cur_frame;
        i_is_kernel     <= kernel;
        i_is_writable   <= wr;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Hold off new requests until every owed page entry has come back and the block
    // is idle. Step one edge first so the monitor has noted the last accepted beat.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0 || busy !== 1'b0)
            @(posedge i_clk);
        // every request yields a result, so a short margin covers the return to idle
        repeat (4) @(posedge i_clk);
    endtask

    // Write frame_count through its own channel; the block must be idle here.
    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        tracker.set_frame_count(value);
    endtask

    // Random request: mostly unmapped entries that allocate, the rest already mapped
    // with a random nonzero frame.
    task automatic send_random_request();
        logic [FRAME_W-1:0] cur_frame;
        cur_frame = '0;
        if ($urandom_range(99) < 35) begin
            cur_frame = FRAME_W'($urandom);
            if (cur_frame == '0)
                cur_frame = FRAME_W'(1);
        end
        send_request(cur_frame, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    initial begin
        int unsigned      phase;
        int unsigned      n;
        logic [CFG_W-1:0] count_value;

        tracker         = new();
        idle_pct        = 0;
        quiet_cycles    = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_current_frame = '0;
        i_is_kernel     = 1'b0;
        i_is_writable   = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: frame zero comes out first, then every flag combination.
        send_request('0, 1'b0, 1'b0);
        send_request('0, 1'b1, 1'b1);
        send_request('0, 1'b0, 1'b1);
        send_request('0, 1'b1, 1'b0);
        // Already-mapped entries at the field extremes and alternating bits.
        send_request(20'hFFFFF, 1'b1, 1'b1);
        send_request(20'h00001, 1'b0, 1'b0);
        send_request(20'h80000, 1'b0, 1'b1);
        send_request(20'h55555, 1'b1, 1'b0);
        send_request(20'hAAAAA, 1'b0, 1'b1);
        drain_results();

        // Zero frames: every allocation reports out of frames.
        write_frame_count('0);
        send_request('0, 1'b0, 1'b1);
        send_request('0, 1'b1, 1'b0);
        drain_results();

        // Count just above what is in use: two allocations, then the pool is empty.
        write_frame_count(16'd6);
        send_request('0, 1'b0, 1'b0);
        send_request('0, 1'b1, 1'b1);
        send_request('0, 1'b0, 1'b1);
        drain_results();

        // Count beyond capacity saturates to the full bitmap.
        write_frame_count(16'hFFFF);
        send_request('0, 1'b1, 1'b1);
        send_request('0, 1'b0, 1'b0);
        send_request(20'h00003, 1'b1, 1'b0);
        drain_results();

        write_frame_count(16'd32768);
        send_request('0, 1'b0, 1'b1);
        drain_results();

        // Random phases: new frame_count each time, rotating the sender idle rate.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(5))
                0: count_value = CFG_W'($urandom_range(64));
                1: count_value = CFG_W'(tracker.frames_in_use + $urandom_range(6));
                2: count_value = 16'd32768;
                3: count_value = CFG_W'($urandom_range(65535, 32769));
                4: count_value = CFG_W'($urandom);
                default: count_value = CFG_W'(tracker.frames_in_use + $urandom_range(40));
            endcase
            write_frame_count(count_value);
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 76;
                default: idle_pct = 9;
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_request();
            drain_results();
        end

        // Close on the extremes of frame_count again.
        idle_pct = 0;
        write_frame_count('0);
        send_request('0, 1'b1, 1'b1);
        drain_results();
        write_frame_count(16'hFFFF);
        send_request('0, 1'b0, 1'b1);
        drain_results();

        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
